// ===== sv/xxh64_pkg.sv =====
`default_nettype none
package xxh64_pkg;

  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED = 4'h0;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_WB   = 6'b000100,
    S_FIN  = 6'b001000,
    S_TAIL = 6'b010000,
    S_DISP = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_L1, OP_L2, OP_M1, OP_M2, OP_M3, OP_T1, OP_T2, OP_T3,
    OP_Q1, OP_Q2, OP_B1, OP_B2, OP_A1, OP_A2
  } op_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

// ===== sv/xxh64_stream_hasher.sv =====
// Per word: a full word that closes no stripe is buffered; a stripe-closing word
//   runs 8 multiplies on one 32x32 multiplier (three partial products each).
// Last item: adds merge (12 multiplies, only if 32 or more bytes in total), tail rounds
//   (3, 2 or 2 multiplies each) and avalanche (2 multiplies), all on the shared unit.
// Throughput: one item at a time; in_tready is high only in the idle state.
// Reset: synchronous active-low; seed clears to 0 and lanes reload from it.
`default_nettype none
module xxh64_stream_hasher #(
  parameter int LENGTH_BITS = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [xxh64_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_word[63:0], byte_count[67:64]
  input  wire                                in_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [xxh64_pkg::OUT_TDATA_W-1:0]  out_tdata,  // hash_value[63:0]
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [xxh64_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire [63:0]                         cfg_pwdata,
  output logic [63:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import xxh64_pkg::*;

  state_t st_r, st_nxt;
  op_t    op_r, op_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] lane_nxt [4];
  logic [63:0] buf_r [3];
  logic        buf_we;
  logic [1:0]  buf_wa;
  logic [1:0]  wis_r, wis_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] word_r, word_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, p_r, p_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic [31:0] mx, my;
  logic [63:0] prod;
  logic        cfg_wr;
  logic [63:0] in_word;
  logic [3:0]  in_bc;
  logic [63:0] merge_sum;
  logic        len_ge32;

  assign in_word    = in_tdata[63:0];
  assign in_bc      = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = seed_r;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign mx   = (ph_r == 2'd2) ? ma_r[63:32] : ma_r[31:0];
  assign my   = (ph_r == 2'd1) ? mb_r[63:32] : mb_r[31:0];
  assign prod = mx * my;

  assign merge_sum   = rotl64(lane_r[0], 1) + rotl64(lane_r[1], 7)
                     + rotl64(lane_r[2], 12) + rotl64(lane_r[3], 18);
  assign len_ge32    = |len_r[LENGTH_BITS-1:5];

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    seed_nxt      = seed_r;
    for (int i = 0; i < 4; i++) lane_nxt[i] = lane_r[i];
    buf_we        = 1'b0;
    buf_wa        = wis_r;
    wis_nxt       = wis_r;
    len_nxt       = len_r;
    h_nxt         = h_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    p_nxt         = (st_r != S_MUL) ? p_r :
                    (ph_r == 2'd0) ? prod : p_r + {prod[31:0], 32'h0};
    ph_nxt        = ph_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          word_nxt = in_word;
          last_nxt = in_tlast;
          cnt_nxt  = (in_tlast && in_bc < 4'd8) ? in_bc[2:0] : 3'd0;
          if (!in_tlast || in_bc == 4'd8) begin
            len_nxt = len_r + LENGTH_BITS'(8);
            if (wis_r != 2'd3) begin
              buf_we  = 1'b1;
              wis_nxt = wis_r + 2'd1;
              if (in_tlast) st_nxt = S_FIN;
            end else begin
              wis_nxt = 2'd0;
              idx_nxt = 2'd0;
              op_nxt  = OP_L1;
              ma_nxt  = buf_r[0];
              mb_nxt  = PR2;
              ph_nxt  = 2'd0;
              st_nxt  = S_MUL;
            end
          end else begin
            len_nxt = len_r + LENGTH_BITS'(in_bc);
            st_nxt  = S_FIN;
          end
        end
      end
      S_MUL: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) st_nxt = S_WB;
      end
      S_FIN: begin
        idx_nxt = 2'd0;
        if (len_ge32) begin
          h_nxt  = merge_sum;
          op_nxt = OP_M1;
          ma_nxt = lane_r[0];
          mb_nxt = PR2;
          ph_nxt = 2'd0;
          st_nxt = S_MUL;
        end else begin
          h_nxt  = seed_r + PR5;
          st_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        h_nxt   = h_r + 64'(len_r);
        idx_nxt = 2'd0;
        st_nxt  = S_DISP;
      end
      S_DISP: begin
        ph_nxt = 2'd0;
        st_nxt = S_MUL;
        if (idx_r < wis_r) begin
          op_nxt = OP_T1;
          ma_nxt = buf_r[idx_r];
          mb_nxt = PR2;
        end else if (cnt_r >= 3'd4) begin
          op_nxt = OP_Q1;
          ma_nxt = {32'h0, word_r[31:0]};
          mb_nxt = PR1;
        end else if (cnt_r != 3'd0) begin
          op_nxt = OP_B1;
          ma_nxt = {56'h0, word_r[7:0]};
          mb_nxt = PR5;
        end else begin
          op_nxt = OP_A1;
          ma_nxt = h_r ^ (h_r >> 33);
          mb_nxt = PR2;
        end
      end
      S_WB: begin
        ph_nxt = 2'd0;
        st_nxt = S_MUL;
        unique case (op_r)
          OP_L1: begin
            op_nxt = OP_L2;
            ma_nxt = rotl64(lane_r[idx_r] + p_r, 31);
            mb_nxt = PR1;
          end
          OP_L2: begin
            lane_nxt[idx_r] = p_r;
            if (idx_r == 2'd3) begin
              st_nxt = last_r ? S_FIN : S_IDLE;
            end else begin
              idx_nxt = idx_r + 2'd1;
              op_nxt  = OP_L1;
              ma_nxt  = (idx_r == 2'd2) ? word_r : buf_r[idx_r + 2'd1];
              mb_nxt  = PR2;
            end
          end
          OP_M1, OP_T1: begin
            op_nxt = (op_r == OP_M1) ? OP_M2 : OP_T2;
            ma_nxt = rotl64(p_r, 31);
            mb_nxt = PR1;
          end
          OP_M2: begin
            op_nxt = OP_M3;
            ma_nxt = h_r ^ p_r;
            mb_nxt = PR1;
          end
          OP_M3: begin
            h_nxt = p_r + PR4;
            if (idx_r == 2'd3) begin
              st_nxt = S_TAIL;
            end else begin
              idx_nxt = idx_r + 2'd1;
              op_nxt  = OP_M1;
              ma_nxt  = lane_r[idx_r + 2'd1];
              mb_nxt  = PR2;
            end
          end
          OP_T2: begin
            op_nxt = OP_T3;
            ma_nxt = rotl64(h_r ^ p_r, 27);
            mb_nxt = PR1;
          end
          OP_T3: begin
            h_nxt   = p_r + PR4;
            idx_nxt = idx_r + 2'd1;
            st_nxt  = S_DISP;
          end
          OP_Q1: begin
            op_nxt = OP_Q2;
            ma_nxt = rotl64(h_r ^ p_r, 23);
            mb_nxt = PR2;
          end
          OP_Q2: begin
            h_nxt    = p_r + PR3;
            word_nxt = word_r >> 32;
            cnt_nxt  = cnt_r - 3'd4;
            st_nxt   = S_DISP;
          end
          OP_B1: begin
            op_nxt = OP_B2;
            ma_nxt = rotl64(h_r ^ p_r, 11);
            mb_nxt = PR1;
          end
          OP_B2: begin
            h_nxt    = p_r;
            word_nxt = word_r >> 8;
            cnt_nxt  = cnt_r - 3'd1;
            st_nxt   = S_DISP;
          end
          OP_A1: begin
            op_nxt = OP_A2;
            ma_nxt = p_r ^ (p_r >> 29);
            mb_nxt = PR3;
          end
          OP_A2: begin
            if (out_valid_r && !out_tready) begin
              st_nxt = S_WB;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = p_r ^ (p_r >> 32);
              lane_nxt[0]   = seed_r + PR1 + PR2;
              lane_nxt[1]   = seed_r + PR2;
              lane_nxt[2]   = seed_r;
              lane_nxt[3]   = seed_r - PR1;
              wis_nxt       = 2'd0;
              len_nxt       = '0;
              st_nxt        = S_IDLE;
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg_wr && cfg_paddr == REG_SEED) begin
      seed_nxt    = cfg_pwdata;
      lane_nxt[0] = cfg_pwdata + PR1 + PR2;
      lane_nxt[1] = cfg_pwdata + PR2;
      lane_nxt[2] = cfg_pwdata;
      lane_nxt[3] = cfg_pwdata - PR1;
      wis_nxt     = 2'd0;
      len_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[buf_wa] <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      op_r        <= OP_L1;
      seed_r      <= '0;
      lane_r[0]   <= PR1 + PR2;
      lane_r[1]   <= PR2;
      lane_r[2]   <= '0;
      lane_r[3]   <= -PR1;
      wis_r       <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      op_r        <= op_nxt;
      seed_r      <= seed_nxt;
      for (int i = 0; i < 4; i++) lane_r[i] <= lane_nxt[i];
      wis_r       <= wis_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    word_r     <= word_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
  end

  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_MUL |-> ph_r != 2'd3) else $error("multiply phase overrun");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_WB && op_r == OP_A2))
    else $error("result raised outside final round");
  a_wis_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_MUL && !cfg_wr |=> $stable(wis_r)) else $error("stripe count moved mid-multiply");
  a_cnt_tail: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DISP |-> idx_r <= wis_r) else $error("tail counters out of range");

endmodule
`default_nettype wire
